FILE: src/setc_pkg.sv
package setc_pkg;

   localparam int unsigned DividendWidth = 64;
   localparam int unsigned DivisorWidth  = 32;
   localparam int unsigned CountWidth    = $clog2(DividendWidth + 1);

   localparam logic [26:0] PixClock     = 27'd74250000;
   localparam logic [26:0] GainTen      = 27'd10;
   localparam logic [8:0]  GainCap      = 9'd480;
   localparam logic [19:0] FrameMin     = 20'h0044c;
   localparam logic [19:0] FrameMax     = 20'hfffff;
   localparam logic [19:0] FrameDefault = 20'd1125;
   localparam logic [19:0] CoarseMargin = 20'd5;
   localparam logic [13:0] AddrGainLo   = 14'h3204;
   localparam logic [13:0] AddrVmax     = 14'h3010;
   localparam logic [13:0] AddrShs      = 14'h308d;
   localparam logic [3:0]  TopMask      = 4'hf;

   typedef enum logic [1:0] {
      OP_GAIN     = 2'd0,
      OP_EXPOSURE = 2'd1,
      OP_RATE     = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_GAIN_MIN    = 3'd0,
      REG_GAIN_MAX    = 3'd1,
      REG_GAIN_SCALE  = 3'd2,
      REG_RATE_SCALE  = 3'd3,
      REG_LINE_CLOCKS = 3'd4,
      REG_TIME_SCALE  = 3'd5,
      REG_SPARE6      = 3'd6,
      REG_SPARE7      = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DSTART1,
      ST_DWAIT1,
      ST_DSTART2,
      ST_DWAIT2,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                            start;
      logic [DividendWidth-1:0]        dividend;
      logic [DivisorWidth-1:0]         divisor;
   } div_req_type;

   typedef struct packed {
      logic                            done;
      logic [DividendWidth-1:0]        quotient;
   } div_rsp_type;

endpackage

FILE: src/setc_div.sv
module setc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  setc_pkg::div_req_type div_req,
   output setc_pkg::div_rsp_type div_rsp
);

   logic [setc_pkg::DividendWidth-1:0] quo_ff, quo_in;
   logic [setc_pkg::DivisorWidth-1:0]  rem_ff, rem_in;
   logic [setc_pkg::DivisorWidth-1:0]  dsr_ff;
   logic [setc_pkg::CountWidth-1:0]    cnt_ff, cnt_in;
   logic                               done_ff, done_in;
   logic [setc_pkg::DivisorWidth:0]    trial;
   logic                               ge;

   // One quotient bit is settled per cycle by a restoring step.
   always_comb begin
      trial   = {rem_ff, quo_ff[setc_pkg::DividendWidth-1]};
      ge      = (trial >= {1'b0, dsr_ff});
      quo_in  = {quo_ff[setc_pkg::DividendWidth-2:0], ge};
      rem_in  = ge ? setc_pkg::DivisorWidth'(trial - {1'b0, dsr_ff})
                   : trial[setc_pkg::DivisorWidth-1:0];
      cnt_in  = cnt_ff - setc_pkg::CountWidth'(1);
      done_in = (cnt_ff == setc_pkg::CountWidth'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (div_req.start) begin
         cnt_ff  <= setc_pkg::CountWidth'(setc_pkg::DividendWidth);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= div_req.dividend;
         rem_ff <= '0;
         dsr_ff <= div_req.divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: src/sensor_exposure_timing_calc.sv
// A gain item passes through one division and a frame rate or exposure item through two; a
// rejected item shows its error result in the cycle after it is accepted.
// One item is handled at a time: a new item is taken only once the sequencer is idle again,
// and both divisions of an item use the single shared divider.
// Reset is synchronous and active high: it restores the register defaults, sets the
// frame length to 1125 and returns the sequencer to idle.
module sensor_exposure_timing_calc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // reg_addr, reg_byte, zero padding
   output logic        rsp_tuser,   // bad_request
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   setc_pkg::state_type   state_ff, state_in;
   setc_pkg::op_type      op_ff;
   setc_pkg::div_req_type div_req;
   setc_pkg::div_rsp_type div_rsp;

   logic [15:0] gain_min_ff, gain_max_ff, line_clocks_ff;
   logic [9:0]  gain_scale_ff;
   logic [19:0] rate_scale_ff, time_scale_ff;
   logic [19:0] frame_lines_ff, frame_lines_in;
   logic [31:0] val_ff;
   logic [58:0] prod_ff;
   logic [63:0] quo_ff;
   logic [19:0] res_ff, res_in;
   logic        bad_ff;
   logic [1:0]  idx_ff;
   logic [1:0]  last_idx;
   logic [13:0] base;
   logic        req_bad;
   logic        accept;
   logic [31:0] mul_a;
   logic [26:0] mul_b;
   logic [15:0] gain_val;
   logic [19:0] limit, lines;
   logic [7:0]  byte_out;
   logic [13:0] addr_out;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_min_ff    <= 16'd0;
         gain_max_ff    <= 16'd480;
         gain_scale_ff  <= 10'd10;
         rate_scale_ff  <= 20'd1000000;
         line_clocks_ff <= 16'd1100;
         time_scale_ff  <= 20'd1000000;
      end else if (csr_valid && csr_ready) begin
         unique case (setc_pkg::reg_index_type'(csr_index))
            setc_pkg::REG_GAIN_MIN:    gain_min_ff    <= csr_data[15:0];
            setc_pkg::REG_GAIN_MAX:    gain_max_ff    <= csr_data[15:0];
            setc_pkg::REG_GAIN_SCALE:  gain_scale_ff  <= csr_data[9:0];
            setc_pkg::REG_RATE_SCALE:  rate_scale_ff  <= csr_data[19:0];
            setc_pkg::REG_LINE_CLOCKS: line_clocks_ff <= csr_data[15:0];
            setc_pkg::REG_TIME_SCALE:  time_scale_ff  <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (setc_pkg::op_type'(req_tuser))
         setc_pkg::OP_GAIN:     req_bad = (gain_scale_ff == '0);
         setc_pkg::OP_RATE:     req_bad = (req_tdata == '0) || (line_clocks_ff == '0);
         setc_pkg::OP_EXPOSURE: req_bad = (time_scale_ff == '0) || (line_clocks_ff == '0);
         default:               req_bad = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         setc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_bad) begin
                  state_in = setc_pkg::ST_EMIT;
               end else if (setc_pkg::op_type'(req_tuser) != setc_pkg::OP_UNUSED) begin
                  state_in = setc_pkg::ST_MUL;
               end
            end
         end
         setc_pkg::ST_MUL:     state_in = setc_pkg::ST_DSTART1;
         setc_pkg::ST_DSTART1: state_in = setc_pkg::ST_DWAIT1;
         setc_pkg::ST_DWAIT1: begin
            if (div_rsp.done) begin
               state_in = (op_ff == setc_pkg::OP_GAIN) ? setc_pkg::ST_CALC
                                                        : setc_pkg::ST_DSTART2;
            end
         end
         setc_pkg::ST_DSTART2: state_in = setc_pkg::ST_DWAIT2;
         setc_pkg::ST_DWAIT2: begin
            if (div_rsp.done) begin
               state_in = setc_pkg::ST_CALC;
            end
         end
         setc_pkg::ST_CALC:    state_in = setc_pkg::ST_EMIT;
         setc_pkg::ST_EMIT: begin
            if (rsp_tready && rsp_tlast) begin
               state_in = setc_pkg::ST_IDLE;
            end
         end
         default:              state_in = setc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == setc_pkg::ST_IDLE);
      rsp_tvalid = (state_ff == setc_pkg::ST_EMIT);
      div_req.start    = (state_ff == setc_pkg::ST_DSTART1)
                      || (state_ff == setc_pkg::ST_DSTART2);
      div_req.dividend = (state_ff == setc_pkg::ST_DSTART1) ? {5'd0, prod_ff} : quo_ff;
      if (state_ff == setc_pkg::ST_DSTART1) begin
         unique case (op_ff)
            setc_pkg::OP_GAIN: div_req.divisor = {22'd0, gain_scale_ff};
            setc_pkg::OP_RATE: div_req.divisor = {16'd0, line_clocks_ff};
            default:           div_req.divisor = {12'd0, time_scale_ff};
         endcase
      end else begin
         div_req.divisor = (op_ff == setc_pkg::OP_RATE) ? val_ff : {16'd0, line_clocks_ff};
      end
   end

   setc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (val_ff[15:0] < gain_min_ff && val_ff[31:16] == '0) begin
         gain_val = gain_min_ff;
      end else if (val_ff > {16'd0, gain_max_ff}) begin
         gain_val = gain_max_ff;
      end else begin
         gain_val = val_ff[15:0];
      end
      unique case (op_ff)
         setc_pkg::OP_GAIN: begin
            mul_a = {16'd0, gain_val};
            mul_b = setc_pkg::GainTen;
         end
         setc_pkg::OP_RATE: begin
            mul_a = {12'd0, rate_scale_ff};
            mul_b = setc_pkg::PixClock;
         end
         default: begin
            mul_a = val_ff;
            mul_b = setc_pkg::PixClock;
         end
      endcase
   end

   always_comb begin
      frame_lines_in = frame_lines_ff;
      limit = (frame_lines_ff > setc_pkg::CoarseMargin)
            ? frame_lines_ff - setc_pkg::CoarseMargin : '0;
      lines = (quo_ff > {44'd0, limit}) ? limit : quo_ff[19:0];
      if (lines == '0) begin
         lines = 20'd1;
      end
      unique case (op_ff)
         setc_pkg::OP_GAIN: begin
            res_in = (quo_ff > {55'd0, setc_pkg::GainCap}) ? {11'd0, setc_pkg::GainCap}
                                                           : quo_ff[19:0];
         end
         setc_pkg::OP_RATE: begin
            if (quo_ff < {44'd0, setc_pkg::FrameMin}) begin
               res_in = setc_pkg::FrameMin;
            end else if (quo_ff > {44'd0, setc_pkg::FrameMax}) begin
               res_in = setc_pkg::FrameMax;
            end else begin
               res_in = quo_ff[19:0];
            end
            frame_lines_in = res_in;
         end
         default: res_in = frame_lines_ff - lines - 20'd1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= setc_pkg::ST_IDLE;
         frame_lines_ff <= setc_pkg::FrameDefault;
         bad_ff         <= 1'b0;
         idx_ff         <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            bad_ff <= req_bad;
            idx_ff <= '0;
         end else if (state_ff == setc_pkg::ST_CALC) begin
            frame_lines_ff <= frame_lines_in;
         end else if (rsp_tvalid && rsp_tready) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= setc_pkg::op_type'(req_tuser);
         val_ff <= req_tdata;
      end
      if (state_ff == setc_pkg::ST_MUL) begin
         prod_ff <= {27'd0, mul_a} * {32'd0, mul_b};
      end
      if (div_rsp.done) begin
         quo_ff <= div_rsp.quotient;
      end
      if (state_ff == setc_pkg::ST_CALC) begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      unique case (op_ff)
         setc_pkg::OP_GAIN: begin
            base     = setc_pkg::AddrGainLo;
            last_idx = 2'd1;
         end
         setc_pkg::OP_RATE: begin
            base     = setc_pkg::AddrVmax;
            last_idx = 2'd2;
         end
         default: begin
            base     = setc_pkg::AddrShs;
            last_idx = 2'd2;
         end
      endcase
      case (idx_ff)
         2'd0:    byte_out = res_ff[7:0];
         2'd1:    byte_out = res_ff[15:8];
         default: byte_out = {4'd0, res_ff[19:16] & setc_pkg::TopMask};
      endcase
      addr_out = base + {12'd0, idx_ff};
      if (bad_ff) begin
         rsp_tdata = '0;
         rsp_tlast = 1'b1;
      end else begin
         rsp_tdata = {2'd0, byte_out, addr_out};
         rsp_tlast = (idx_ff == last_idx);
      end
      rsp_tuser = bad_ff;
   end

endmodule

FILE: src/setc_checker.sv
module setc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A held result keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // No new item is taken while results are still being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during result delivery");

   // An accepted item with a known operation keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready
      && (setc_pkg::op_type'(req_tuser) != setc_pkg::OP_UNUSED) |=> !req_tready)
      else $error("ready straight after an accepted item");

   // An error result is the only and final one and carries no write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("malformed error result");

endmodule

bind sensor_exposure_timing_calc setc_checker u_setc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/sensor_exposure_timing_calc_test.sv
module sensor_exposure_timing_calc_test;

   typedef struct {
      setc_pkg::op_type op;
      logic [31:0]      value;
   } request_type;

   typedef struct {
      logic [13:0] addr;
      logic [7:0]  data;
      logic        bad;
      logic        last;
   } reg_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   request_type   pending_requests[$];
   reg_write_type expected_writes[$];
   int unsigned   error_count = 0;
   int unsigned   req_gap = 0;
   int unsigned   rsp_stall = 0;
   bit            burst_mode = 0;

   logic [15:0] m_gain_min = 16'd0;
   logic [15:0] m_gain_max = 16'd480;
   logic [9:0]  m_gain_scale = 10'd10;
   logic [19:0] m_rate_scale = 20'd1000000;
   logic [15:0] m_line_clocks = 16'd1100;
   logic [19:0] m_time_scale = 20'd1000000;
   logic [19:0] m_frame_lines = setc_pkg::FrameDefault;

   sensor_exposure_timing_calc u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void push_write(logic [13:0] addr, logic [7:0] data, logic bad,
                                      logic last);
      reg_write_type w;
      w.addr = addr;
      w.data = data;
      w.bad  = bad;
      w.last = last;
      expected_writes.push_back(w);
   endfunction

   function automatic void push_three(logic [13:0] base, logic [23:0] v);
      push_write(base, v[7:0], 1'b0, 1'b0);
      push_write(base + 14'd1, v[15:8], 1'b0, 1'b0);
      push_write(base + 14'd2, {4'h0, v[19:16] & setc_pkg::TopMask}, 1'b0, 1'b1);
   endfunction

   function automatic void predict_writes(request_type r);
      logic [63:0] v;
      logic [63:0] q;
      logic [63:0] limit;
      logic [31:0] shs;
      v = {32'h0, r.value};
      case (r.op)
         setc_pkg::OP_GAIN: begin
            if (m_gain_scale == 0) begin
               push_write('0, '0, 1'b1, 1'b1);
            end else begin
               if (v < 64'(m_gain_min)) v = 64'(m_gain_min);
               else if (v > 64'(m_gain_max)) v = 64'(m_gain_max);
               q = (v * 64'd10) / 64'(m_gain_scale);
               if (q > 64'(setc_pkg::GainCap)) q = 64'(setc_pkg::GainCap);
               push_write(setc_pkg::AddrGainLo, q[7:0], 1'b0, 1'b0);
               push_write(setc_pkg::AddrGainLo + 14'd1, q[15:8], 1'b0, 1'b1);
            end
         end
         setc_pkg::OP_RATE: begin
            if (v == 0 || m_line_clocks == 0) begin
               push_write('0, '0, 1'b1, 1'b1);
            end else begin
               q = 64'(setc_pkg::PixClock) * 64'(m_rate_scale) / 64'(m_line_clocks) / v;
               if (q < 64'(setc_pkg::FrameMin)) q = 64'(setc_pkg::FrameMin);
               else if (q > 64'(setc_pkg::FrameMax)) q = 64'(setc_pkg::FrameMax);
               m_frame_lines = q[19:0];
               push_three(setc_pkg::AddrVmax, {4'h0, m_frame_lines});
            end
         end
         setc_pkg::OP_EXPOSURE: begin
            if (m_time_scale == 0 || m_line_clocks == 0) begin
               push_write('0, '0, 1'b1, 1'b1);
            end else begin
               q = v * 64'(setc_pkg::PixClock) / 64'(m_time_scale) / 64'(m_line_clocks);
               limit = (m_frame_lines > setc_pkg::CoarseMargin)
                     ? 64'(m_frame_lines - setc_pkg::CoarseMargin) : 64'd0;
               if (q > limit) q = limit;
               if (q < 64'd1) q = 64'd1;
               shs = (32'(m_frame_lines) - q[31:0] - 32'd1) & 32'hffffff;
               push_three(setc_pkg::AddrShs, shs[23:0]);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int unsigned draw_gap();
      return burst_mode ? 0 : $urandom_range(0, 12);
   endfunction

   always @(posedge clock) begin
      request_type r;
      int unsigned g;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (req_tvalid && req_tready) begin
         predict_writes('{setc_pkg::op_type'(req_tuser), req_tdata});
         g = draw_gap();
         if (g == 0 && pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_tdata <= r.value;
            req_tuser <= r.op;
         end else begin
            req_tvalid <= 1'b0;
            req_gap <= g;
         end
      end else if (!req_tvalid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= r.value;
            req_tuser <= r.op;
         end
      end
   end

   always @(posedge clock) begin
      reg_write_type w;
      int unsigned n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_writes.size() == 0) begin
            $error("unexpected item addr %h byte %h", rsp_tdata[13:0], rsp_tdata[21:14]);
            error_count++;
         end else begin
            w = expected_writes.pop_front();
            if (rsp_tdata[13:0] !== w.addr) begin
               $error("reg_addr expected %h actual %h", w.addr, rsp_tdata[13:0]);
               error_count++;
            end
            if (rsp_tdata[21:14] !== w.data) begin
               $error("reg_byte expected %h actual %h", w.data, rsp_tdata[21:14]);
               error_count++;
            end
            if (rsp_tuser !== w.bad) begin
               $error("bad_request expected %b actual %b", w.bad, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== w.last) begin
               $error("last expected %b actual %b", w.last, rsp_tlast);
               error_count++;
            end
         end
         n = draw_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall <= n;
         end
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         if (rsp_stall == 1) rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_tvalid || expected_writes.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(setc_pkg::reg_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         setc_pkg::REG_GAIN_MIN:    m_gain_min    = data[15:0];
         setc_pkg::REG_GAIN_MAX:    m_gain_max    = data[15:0];
         setc_pkg::REG_GAIN_SCALE:  m_gain_scale  = data[9:0];
         setc_pkg::REG_RATE_SCALE:  m_rate_scale  = data[19:0];
         setc_pkg::REG_LINE_CLOCKS: m_line_clocks = data[15:0];
         setc_pkg::REG_TIME_SCALE:  m_time_scale  = data[19:0];
         default: ;
      endcase
   endtask

   task automatic add_request(setc_pkg::op_type op, logic [31:0] value);
      pending_requests.push_back('{op, value});
   endtask

   function automatic logic [31:0] pick(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 300);
         2: return $urandom_range(0, 100000);
         3: return $urandom_range(0, 2000000);
         default: return $urandom_range(0, 1000);
      endcase
   endfunction

   initial begin
      int unsigned k;
      int unsigned op_draw;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_request(setc_pkg::OP_GAIN, 32'd0);
      add_request(setc_pkg::OP_GAIN, 32'd250);
      add_request(setc_pkg::OP_GAIN, 32'hffffffff);
      add_request(setc_pkg::OP_RATE, 32'd0);
      add_request(setc_pkg::OP_RATE, 32'd1);
      add_request(setc_pkg::OP_RATE, 32'd60);
      add_request(setc_pkg::OP_RATE, 32'hffffffff);
      add_request(setc_pkg::OP_EXPOSURE, 32'd0);
      add_request(setc_pkg::OP_EXPOSURE, 32'd33333);
      add_request(setc_pkg::OP_EXPOSURE, 32'hffffffff);
      add_request(setc_pkg::OP_UNUSED, 32'h5a5a5a5a);
      add_request(setc_pkg::OP_RATE, 32'd30);
      add_request(setc_pkg::OP_EXPOSURE, 32'd1);
      wait_idle();

      csr_write(setc_pkg::REG_GAIN_MIN, 32'd300);
      csr_write(setc_pkg::REG_GAIN_MAX, 32'd100);
      csr_write(setc_pkg::REG_GAIN_SCALE, 32'd0);
      csr_write(setc_pkg::REG_LINE_CLOCKS, 32'd0);
      csr_write(setc_pkg::REG_TIME_SCALE, 32'd0);
      csr_write(setc_pkg::REG_RATE_SCALE, 32'd1);
      add_request(setc_pkg::OP_GAIN, 32'd5);
      add_request(setc_pkg::OP_RATE, 32'd60);
      add_request(setc_pkg::OP_EXPOSURE, 32'd1000);
      wait_idle();

      csr_write(setc_pkg::REG_GAIN_SCALE, 32'd1);
      csr_write(setc_pkg::REG_LINE_CLOCKS, 32'd65535);
      csr_write(setc_pkg::REG_TIME_SCALE, 32'd1);
      add_request(setc_pkg::OP_GAIN, 32'd5);
      add_request(setc_pkg::OP_GAIN, 32'd1000);
      add_request(setc_pkg::OP_RATE, 32'd1);
      add_request(setc_pkg::OP_EXPOSURE, 32'd12345);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         csr_write(setc_pkg::REG_GAIN_MIN, pick(0, 65535) >> ($urandom_range(0, 1) * 8));
         csr_write(setc_pkg::REG_GAIN_MAX, pick(0, 65535));
         csr_write(setc_pkg::REG_GAIN_SCALE,
                   ($urandom_range(0, 9) == 0) ? 0 : pick(1, 1000));
         csr_write(setc_pkg::REG_RATE_SCALE, pick(1, 1000000));
         csr_write(setc_pkg::REG_LINE_CLOCKS,
                   ($urandom_range(0, 9) == 0) ? 0 : pick(1, 65535));
         csr_write(setc_pkg::REG_TIME_SCALE,
                   ($urandom_range(0, 9) == 0) ? 0 : pick(1, 1000000));
         for (k = 0; k < 58; k++) begin
            op_draw = $urandom_range(0, 19);
            if (op_draw == 0) add_request(setc_pkg::OP_UNUSED, $urandom());
            else add_request(setc_pkg::op_type'(op_draw % 3), random_value());
         end
         burst_mode = (phase % 3 == 1);
         wait_idle();
         burst_mode = 0;
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
